FILE: design/lcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// shared sizes, codes and transfer types of the lcs length and trace block
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int MAX_LEN     = 64;
   localparam int SYMBOL_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAX_LEN);
   localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
   localparam int CNT_BITS    = $clog2(MAX_LEN + 1);
   localparam int TAB_BITS    = 2 * IDX_BITS;

   localparam logic SEL_A = 1'b0;
   localparam logic SEL_B = 1'b1;

   typedef struct packed {
      logic        seq_select;
      logic [15:0] symbol;
      logic        has_symbol;
      logic        last_of_seq;
   } req_type;

   typedef struct packed {
      logic [15:0] out_symbol;
      logic        is_last;
      logic        no_match;
      logic        truncated;
   } rsp_type;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] a_sym;
      logic [SYMBOL_BITS-1:0] b_sym;
      logic [CNT_BITS-1:0]    down;
      logic [CNT_BITS-1:0]    right;
      logic [CNT_BITS-1:0]    diag;
      logic                   last_row;
      logic                   col_end;
   } cell_in_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] val;
      logic                sym_eq;
   } cell_out_type;

endpackage

FILE: design/lcs_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_table_ram
// generic memory with one write port and two registered read ports
// ----------------------------------------------------------------------------
module lcs_table_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 7
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_x,
   input  logic [ADDR_BITS-1:0] rd_addr_y,
   output logic [DATA_BITS-1:0] rd_data_x,
   output logic [DATA_BITS-1:0] rd_data_y
);

   logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_x <= mem[rd_addr_x];
      rd_data_y <= mem[rd_addr_y];
   end

endmodule

FILE: design/lcs_cell_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_cell_unit
// shared symbol compare and max/increment unit for table fill and trace-back
// ----------------------------------------------------------------------------
module lcs_cell_unit (
   input  lcs_pkg::cell_in_type  cell_in,
   output lcs_pkg::cell_out_type cell_out
);

   logic [lcs_pkg::CNT_BITS-1:0] down;
   logic [lcs_pkg::CNT_BITS-1:0] right;
   logic [lcs_pkg::CNT_BITS-1:0] diag;

   always_comb begin
      down  = cell_in.last_row ? '0 : cell_in.down;
      right = cell_in.col_end ? '0 : cell_in.right;
      diag  = (cell_in.last_row || cell_in.col_end) ? '0 : cell_in.diag;
      cell_out.sym_eq = (cell_in.a_sym == cell_in.b_sym);
      if (cell_out.sym_eq) begin
         cell_out.val = diag + lcs_pkg::CNT_BITS'(1);
      end else begin
         cell_out.val = (down > right) ? down : right;
      end
   end

endmodule

FILE: design/lcs_length_and_trace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_and_trace
// loads: the item ending sequence b starts a run
// run: a start state, a fill of all len_a*len_b cells (one cell per cycle), a drain
//   state, trace-back steps of a read and an evaluate state (at most len_a + len_b - 1
//   steps), a final check and the load of the last result, plus result stalls;
//   with either sequence empty the run is the start state and the final load alone
// runs: one at a time, since loads are taken only while idle
// reset: synchronous, clears control and lengths; memories have no clearing pass
// ----------------------------------------------------------------------------
module lcs_length_and_trace (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lcs_pkg::rsp_type rsp_data
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_FILL   = 7'b0000100,
      ST_DRAIN  = 7'b0001000,
      ST_TB_RD  = 7'b0010000,
      ST_TB_EV  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   localparam int SB = lcs_pkg::SYMBOL_BITS;
   localparam int IB = lcs_pkg::IDX_BITS;
   localparam int LB = lcs_pkg::LEN_BITS;
   localparam int CB = lcs_pkg::CNT_BITS;
   localparam int TB = lcs_pkg::TAB_BITS;

   state_type state_ff, state_in;
   logic [LB-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          ovf_ff, ovf_in;
   logic [LB-1:0] i_ff, i_in, j_ff, j_in;
   logic          c_vld_ff, c_vld_in;
   logic [IB-1:0] c_i_ff, c_j_ff;
   logic          c_last_row_ff, c_col_end_ff;
   logic          fwd_hit_ff;
   logic [CB-1:0] fwd_val_ff, prev_v_ff, prev_dn_ff;
   logic          pend_vld_ff, pend_vld_in;
   logic [SB-1:0] pend_sym_ff, pend_sym_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lcs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [SB-1:0] mem_a [lcs_pkg::MAX_LEN];
   logic [SB-1:0] mem_b [lcs_pkg::MAX_LEN];
   logic [SB-1:0] a_q, b_q;

   logic          accept;
   logic          a_we, b_we;
   logic          slot_free;
   logic          out_load;
   logic [TB-1:0] addr_x, addr_y, wr_addr;
   logic [CB-1:0] x_q, y_q, dn_eff, tb_down;
   lcs_pkg::cell_in_type  cell_in;
   lcs_pkg::cell_out_type cell_out;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign a_we = accept && req_data.has_symbol && (req_data.seq_select == lcs_pkg::SEL_A)
                 && (len_a_ff < LB'(lcs_pkg::MAX_LEN));
   assign b_we = accept && req_data.has_symbol && (req_data.seq_select == lcs_pkg::SEL_B)
                 && (len_b_ff < LB'(lcs_pkg::MAX_LEN));

   // symbol stores
   always_ff @(posedge clock) begin
      if (a_we) begin
         mem_a[len_a_ff[IB-1:0]] <= SB'(req_data.symbol);
      end
      if (b_we) begin
         mem_b[len_b_ff[IB-1:0]] <= SB'(req_data.symbol);
      end
      a_q <= mem_a[i_ff[IB-1:0]];
      b_q <= mem_b[j_ff[IB-1:0]];
   end

   assign addr_x  = {IB'(i_ff + LB'(1)), j_ff[IB-1:0]};
   assign addr_y  = {i_ff[IB-1:0], j_ff[IB-1:0]};
   assign wr_addr = {c_i_ff, c_j_ff};

   lcs_table_ram #(
      .ADDR_BITS(TB),
      .DATA_BITS(CB)
   ) u_table (
      .clock    (clock),
      .wr_en    (c_vld_ff),
      .wr_addr  (wr_addr),
      .wr_data  (cell_out.val),
      .rd_addr_x(addr_x),
      .rd_addr_y(addr_y),
      .rd_data_x(x_q),
      .rd_data_y(y_q)
   );

   assign dn_eff  = fwd_hit_ff ? fwd_val_ff : x_q;
   assign tb_down = ((i_ff + LB'(1)) == len_a_ff) ? '0 : x_q;

   always_comb begin
      cell_in.a_sym    = a_q;
      cell_in.b_sym    = b_q;
      cell_in.down     = dn_eff;
      cell_in.right    = prev_v_ff;
      cell_in.diag     = prev_dn_ff;
      cell_in.last_row = c_last_row_ff;
      cell_in.col_end  = c_col_end_ff;
   end

   lcs_cell_unit u_cell (
      .cell_in (cell_in),
      .cell_out(cell_out)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      c_vld_in    = 1'b0;
      pend_vld_in = pend_vld_ff;
      pend_sym_in = pend_sym_ff;
      out_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (a_we) begin
                  len_a_in = len_a_ff + LB'(1);
               end
               if (b_we) begin
                  len_b_in = len_b_ff + LB'(1);
               end
               if (req_data.has_symbol && !a_we && !b_we) begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_of_seq && (req_data.seq_select == lcs_pkg::SEL_B)) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if ((len_a_ff == '0) || (len_b_ff == '0)) begin
               state_in = ST_FINISH;
            end else begin
               i_in     = len_a_ff - LB'(1);
               j_in     = len_b_ff - LB'(1);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            c_vld_in = 1'b1;
            if (j_ff == '0) begin
               if (i_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff - LB'(1);
                  j_in = len_b_ff - LB'(1);
               end
            end else begin
               j_in = j_ff - LB'(1);
            end
         end
         ST_DRAIN: begin
            i_in     = '0;
            j_in     = '0;
            state_in = ST_TB_RD;
         end
         ST_TB_RD: begin
            if ((i_ff < len_a_ff) && (j_ff < len_b_ff)) begin
               state_in = ST_TB_EV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TB_EV: begin
            if (cell_out.sym_eq) begin
               if (!pend_vld_ff || slot_free) begin
                  if (pend_vld_ff) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{out_symbol: 16'(pend_sym_ff), is_last: 1'b0,
                                     no_match: 1'b0, truncated: ovf_ff};
                  end
                  pend_vld_in = 1'b1;
                  pend_sym_in = a_q;
                  i_in        = i_ff + LB'(1);
                  j_in        = j_ff + LB'(1);
                  state_in    = ST_TB_RD;
               end
            end else begin
               if (y_q == tb_down) begin
                  i_in = i_ff + LB'(1);
               end else begin
                  j_in = j_ff + LB'(1);
               end
               state_in = ST_TB_RD;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (pend_vld_ff) begin
                  rsp_data_in = '{out_symbol: 16'(pend_sym_ff), is_last: 1'b1,
                                  no_match: 1'b0, truncated: ovf_ff};
               end else begin
                  rsp_data_in = '{out_symbol: '0, is_last: 1'b1,
                                  no_match: 1'b1, truncated: ovf_ff};
               end
               pend_vld_in = 1'b0;
               len_a_in    = '0;
               len_b_in    = '0;
               ovf_in      = 1'b0;
               i_in        = '0;
               j_in        = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         c_vld_ff     <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         c_vld_ff     <= c_vld_in;
         fwd_hit_ff   <= c_vld_ff && (wr_addr == addr_x);
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      c_i_ff        <= i_ff[IB-1:0];
      c_j_ff        <= j_ff[IB-1:0];
      c_last_row_ff <= ((i_ff + LB'(1)) == len_a_ff);
      c_col_end_ff  <= ((j_ff + LB'(1)) == len_b_ff);
      fwd_val_ff    <= cell_out.val;
      if (c_vld_ff) begin
         prev_v_ff  <= cell_out.val;
         prev_dn_ff <= dn_eff;
      end
      pend_sym_ff <= pend_sym_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      (len_a_ff <= LB'(lcs_pkg::MAX_LEN)) && (len_b_ff <= LB'(lcs_pkg::MAX_LEN)))
      else $error("sequence length beyond capacity");

   a_fill_in_range : assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> ((LB'(c_i_ff) < len_a_ff) && (LB'(c_j_ff) < len_b_ff)))
      else $error("table write outside loaded sequences");

   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> ((state_ff == ST_IDLE) || (state_ff == ST_START))
                                && !c_vld_ff)
      else $error("run activity without start");

endmodule
